/* rtl/lifo_stack_with_swap_and_dump_defines.svh */
// assertion macros for the lifo stack rtl
`ifndef LIFO_STACK_WITH_SWAP_AND_DUMP_DEFINES_SVH
`define LIFO_STACK_WITH_SWAP_AND_DUMP_DEFINES_SVH

`ifndef SYNTHESIS
`define LSWD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LSWD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LSWD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSWD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/lswd_pkg.sv */
// shared constants and types for the lifo stack
`timescale 1ns / 1ps
package lswd_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int S_TDATA_W   = ((OP_W + DATA_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = DATA_W;

  localparam logic [OP_W-1:0] OP_EMPTY = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP   = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd3;
  localparam logic [OP_W-1:0] OP_SWAP  = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP  = 3'd5;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  err;
    logic  last;
  } result_t;

endpackage

/* rtl/lswd_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
module lswd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lifo_stack_with_swap_and_dump.sv */
// lifo stack of signed words with query, push, pop, peek, swap-then-dump and dump
// query and push results come from registers; pop and peek results come through the ram read
// a new transaction is taken only in idle, after the last result of the previous one has
// gone into the output register; one ram read per dumped entry
// reset clears the count and control state; the ram is not cleared
`timescale 1ns / 1ps
`include "lifo_stack_with_swap_and_dump_defines.svh"
module lifo_stack_with_swap_and_dump (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] opcode, [34:3] push_value, rest zero
  input  logic [lswd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] result_value
  output logic [lswd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] error
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);
  import lswd_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RESP    = 3'd1;
  localparam logic [2:0] ST_READ    = 3'd2;
  localparam logic [2:0] ST_SWAP_RD = 3'd3;
  localparam logic [2:0] ST_SWAP_WR = 3'd4;
  localparam logic [2:0] ST_SWAP_WB = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] rd_idx_q, rd_idx_d;
  logic              single_q, single_d;
  word_t             tmp_q, tmp_d;
  word_t             resp_val_q, resp_val_d;
  logic              resp_err_q, resp_err_d;
  result_t           out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic [OP_W-1:0]   opcode;
  word_t             push_value;
  logic              accept;
  logic              out_free;
  logic              is_full;
  logic              is_empty;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2, cnt_p1;
  logic [ADDR_W-1:0] top_addr, sec_addr;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  word_t             ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  assign opcode     = s_axis_tdata[OP_W-1:0];
  assign push_value = s_axis_tdata[OP_W+DATA_W-1:OP_W];
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_vld_q || m_axis_tready;
  assign is_full    = (count_q == CNT_W'(STACK_DEPTH));
  assign is_empty   = (count_q == '0);
  assign cnt_m1     = count_q - 1'b1;
  assign cnt_m2     = count_q - 2'd2;
  assign cnt_p1     = count_q + 1'b1;
  assign top_addr   = cnt_m1[ADDR_W-1:0];
  assign sec_addr   = cnt_m2[ADDR_W-1:0];

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    single_d   = single_q;
    tmp_d      = tmp_q;
    resp_val_d = resp_val_q;
    resp_err_d = resp_err_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    ram_we     = 1'b0;
    ram_waddr  = count_q[ADDR_W-1:0];
    ram_wdata  = push_value;
    ram_re     = 1'b0;
    ram_raddr  = top_addr;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          resp_val_d = '1;
          resp_err_d = 1'b1;
          case (opcode)
            OP_EMPTY: begin
              resp_val_d    = '0;
              resp_val_d[0] = is_empty;
              resp_err_d    = 1'b0;
              state_d       = ST_RESP;
            end
            OP_PUSH: begin
              if (!is_full) begin
                ram_we     = 1'b1;
                count_d    = cnt_p1;
                resp_val_d = {{(DATA_W-CNT_W){1'b0}}, cnt_p1};
                resp_err_d = 1'b0;
              end
              state_d = ST_RESP;
            end
            OP_POP, OP_PEEK: begin
              if (is_empty) begin
                state_d = ST_RESP;
              end else begin
                ram_re   = 1'b1;
                single_d = 1'b1;
                rd_idx_d = top_addr;
                if (opcode == OP_POP) begin
                  count_d = cnt_m1;
                end
                state_d = ST_READ;
              end
            end
            OP_SWAP: begin
              if (count_q < CNT_W'(2)) begin
                state_d = ST_RESP;
              end else begin
                ram_re  = 1'b1;
                state_d = ST_SWAP_RD;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                state_d = ST_RESP;
              end else begin
                ram_re   = 1'b1;
                single_d = 1'b0;
                rd_idx_d = top_addr;
                state_d  = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_d     = '{value: resp_val_q, err: resp_err_q, last: 1'b1};
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_d     = '{value: ram_rdata, err: 1'b0, last: single_q || (rd_idx_q == '0)};
          out_vld_d = 1'b1;
          if (single_q || (rd_idx_q == '0)) begin
            state_d = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_idx_q - 1'b1;
            rd_idx_d  = rd_idx_q - 1'b1;
          end
        end
      end
      ST_SWAP_RD: begin
        tmp_d     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = sec_addr;
        state_d   = ST_SWAP_WR;
      end
      ST_SWAP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = top_addr;
        ram_wdata = ram_rdata;
        state_d   = ST_SWAP_WB;
      end
      ST_SWAP_WB: begin
        ram_we    = 1'b1;
        ram_waddr = sec_addr;
        ram_wdata = tmp_q;
        ram_re    = 1'b1;
        rd_idx_d  = top_addr;
        single_d  = 1'b0;
        state_d   = ST_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    single_q   <= single_d;
    tmp_q      <= tmp_d;
    resp_val_q <= resp_val_d;
    resp_err_q <= resp_err_d;
    out_q      <= out_d;
  end

  lswd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.value;
  assign m_axis_tuser  = out_q.err;
  assign m_axis_tlast  = out_q.last;

  `LSWD_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(STACK_DEPTH), "count above depth")
  `LSWD_ASSERT(a_push_count, clk_i, rst_ni, (accept && (opcode == OP_PUSH) && !is_full) |=> (count_q == $past(count_q) + 1'b1), "push did not bump count")
  `LSWD_ASSERT_NEVER(a_no_write_in_read, clk_i, rst_ni, ram_we && (state_q == ST_READ), "ram write while reading out")
  `LSWD_ASSERT(a_last_ends, clk_i, rst_ni, (out_vld_d && out_d.last && out_free && ((state_q == ST_READ) || (state_q == ST_RESP))) |=> (state_q == ST_IDLE), "last result did not end the transaction")

endmodule

/* bench/tb_top.sv */
// self-checking testbench for the lifo stack with swap and dump
`timescale 1ns / 1ps
module tb_top;
  import lswd_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam word_t ERR_WORD     = -32'sd1;
  localparam word_t MAX_WORD     = 32'sh7fff_ffff;
  localparam word_t MIN_WORD     = 32'sh8000_0000;
  localparam int RANDOM_OPS      = 150;
  localparam int SETTLE_CYCLES   = 16;
  localparam int LONG_HOLD       = 250;
  localparam int MAX_PRINTED     = 40;
  localparam longint LIMIT_NS    = 64'd12_000_000;

  typedef enum logic [1:0] {MIX_PHASE, FILL_PHASE, DRAIN_PHASE} phase_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    word_t           val;
    int              reps;
    logic            typed;
    word_t           exp_val;
    logic            exp_err;
  } stim_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  word_t       stack_model [STACK_DEPTH];
  int unsigned stack_level = 0;
  result_t     pending_results [$];
  int          mismatch_count = 0;
  int          stall_req = 0;
  int          stall_done = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  // directed stimulus, expected result typed in where obvious
  stim_row_t script [25] = '{
    '{OP_EMPTY,   32'sd0,        1,  1'b1, 32'sd1,   1'b0},
    '{OP_POP,     32'sd0,        1,  1'b1, ERR_WORD, 1'b1},
    '{OP_PEEK,    32'sd0,        1,  1'b1, ERR_WORD, 1'b1},
    '{OP_SWAP,    32'sd0,        1,  1'b1, ERR_WORD, 1'b1},
    '{OP_DUMP,    32'sd0,        1,  1'b1, ERR_WORD, 1'b1},
    '{OP_SPARE_A, MAX_WORD,      1,  1'b0, 32'sd0,   1'b0},
    '{OP_SPARE_B, ERR_WORD,      1,  1'b0, 32'sd0,   1'b0},
    '{OP_PUSH,    MAX_WORD,      1,  1'b1, 32'sd1,   1'b0},
    '{OP_SWAP,    32'sd0,        1,  1'b1, ERR_WORD, 1'b1},
    '{OP_PUSH,    MIN_WORD,      1,  1'b1, 32'sd2,   1'b0},
    '{OP_PUSH,    ERR_WORD,      1,  1'b1, 32'sd3,   1'b0},
    '{OP_PEEK,    32'sd0,        1,  1'b1, ERR_WORD, 1'b0},
    '{OP_EMPTY,   32'sd0,        1,  1'b1, 32'sd0,   1'b0},
    '{OP_SWAP,    32'sd0,        1,  1'b0, 32'sd0,   1'b0},
    '{OP_DUMP,    32'sd0,        1,  1'b0, 32'sd0,   1'b0},
    '{OP_POP,     32'sd0,        3,  1'b0, 32'sd0,   1'b0},
    '{OP_POP,     32'sd0,        1,  1'b1, ERR_WORD, 1'b1},
    '{OP_PUSH,    32'sh0000_1000, STACK_DEPTH, 1'b0, 32'sd0, 1'b0},
    '{OP_PUSH,    32'sd5,        1,  1'b1, ERR_WORD, 1'b1},
    '{OP_EMPTY,   32'sd0,        1,  1'b1, 32'sd0,   1'b0},
    '{OP_SWAP,    32'sd0,        1,  1'b0, 32'sd0,   1'b0},
    '{OP_DUMP,    32'sd0,        1,  1'b0, 32'sd0,   1'b0},
    '{OP_PEEK,    32'sd0,        1,  1'b0, 32'sd0,   1'b0},
    '{OP_POP,     32'sd0,        STACK_DEPTH, 1'b0, 32'sd0, 1'b0},
    '{OP_EMPTY,   32'sd0,        1,  1'b1, 32'sd1,   1'b0}
  };

  lifo_stack_with_swap_and_dump dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b0;
    #6 clk_i = 1'b1;
  end

  function automatic result_t make_result(word_t v, logic e, logic l);
    result_t r;
    r.value = v;
    r.err   = e;
    r.last  = l;
    return r;
  endfunction

  function automatic void queue_stack_dump();
    if (stack_level == 0) begin
      pending_results.push_back(make_result(ERR_WORD, 1'b1, 1'b1));
    end else begin
      for (int i = stack_level; i > 0; i--)
        pending_results.push_back(make_result(stack_model[i-1], 1'b0, i == 1));
    end
  endfunction

  function automatic void predict_stack_op(logic [OP_W-1:0] op, word_t val);
    word_t tmp;
    case (op)
      OP_EMPTY: begin
        pending_results.push_back(make_result((stack_level == 0) ? 32'sd1 : 32'sd0, 1'b0, 1'b1));
      end
      OP_PUSH: begin
        if (stack_level >= STACK_DEPTH) begin
          pending_results.push_back(make_result(ERR_WORD, 1'b1, 1'b1));
        end else begin
          stack_model[stack_level] = val;
          stack_level++;
          pending_results.push_back(make_result(word_t'(stack_level), 1'b0, 1'b1));
        end
      end
      OP_POP, OP_PEEK: begin
        if (stack_level == 0) begin
          pending_results.push_back(make_result(ERR_WORD, 1'b1, 1'b1));
        end else begin
          pending_results.push_back(make_result(stack_model[stack_level-1], 1'b0, 1'b1));
          if (op == OP_POP) stack_level--;
        end
      end
      OP_SWAP: begin
        if (stack_level < 2) begin
          pending_results.push_back(make_result(ERR_WORD, 1'b1, 1'b1));
        end else begin
          tmp = stack_model[stack_level-1];
          stack_model[stack_level-1] = stack_model[stack_level-2];
          stack_model[stack_level-2] = tmp;
          queue_stack_dump();
        end
      end
      OP_DUMP: begin
        queue_stack_dump();
      end
      default: ;
    endcase
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(0, 7))
      0: return MAX_WORD;
      1: return MIN_WORD;
      2: return ERR_WORD;
      3: return 32'sd0;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // called right after a rising edge, returns at the edge that accepts the transaction
  task automatic offer_op(logic [OP_W-1:0] op, word_t val);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {{(S_TDATA_W - OP_W - DATA_W){1'b0}}, val, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
  endtask

  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    word_t           v;
    logic [OP_W-1:0] op;
    phase_t          phase;
    int              phase_left;
    int              sent;
    int              roll;
    phase      = MIX_PHASE;
    phase_left = 0;
    sent       = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r]) begin
      for (int k = 0; k < script[r].reps; k++) begin
        v = script[r].val ^ word_t'(k * 32'h9e37_79b9);
        offer_op(script[r].op, v);
        predict_stack_op(script[r].op, v);
        if (script[r].typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back(make_result(script[r].exp_val, script[r].exp_err, 1'b1));
        end
      end
    end
    wait_for_idle();

    while (sent < RANDOM_OPS) begin
      if (phase_left == 0) begin
        phase      = phase_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 70);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       op = OP_EMPTY;
        1, 2, 3: op = OP_PUSH;
        4, 5:    op = OP_POP;
        6:       op = OP_PEEK;
        7:       op = OP_SWAP;
        8:       op = OP_DUMP;
        default: begin
          if ($urandom_range(0, 3) == 0) op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
          else op = OP_PEEK;
        end
      endcase
      if (phase == FILL_PHASE && roll < 70) op = OP_PUSH;
      if (phase == DRAIN_PHASE && roll < 50) op = OP_POP;
      v = random_word();
      offer_op(op, v);
      predict_stack_op(op, v);
      if (op != OP_SPARE_A && op != OP_SPARE_B) begin
        sent++;
        // back up the output while input keeps coming
        if (sent == 50) stall_req++;
        if (sent == 100) wait_for_idle();
      end
    end

    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int hold;
    hold = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        hold = rx_calm ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      end
      if (stall_done != stall_req) begin
        hold       = LONG_HOLD;
        stall_done = stall_req;
      end
      m_axis_tready <= (hold == 0);
      if (hold > 0) hold--;
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction value %0d", $signed(m_axis_tdata)));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch($sformatf("value %0d, want %0d", $signed(m_axis_tdata), want.value));
        if (m_axis_tuser !== want.err)
          report_mismatch($sformatf("error flag %b, want %b", m_axis_tuser, want.err));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/lswd_pkg.sv
rtl/lswd_ram.sv
rtl/lifo_stack_with_swap_and_dump.sv
bench/tb_top.sv
